@@ rtl/pna_pkg.sv @@
// Shared types and constants for the pixel noise accumulator.
package pna_pkg;

    localparam int PIX_W           = 13;
    localparam int SMP_W           = 12;
    localparam int SUM_W           = 28;
    localparam int SQ_W            = 38;
    localparam int SIGMA_W         = 20;
    localparam int N_W             = 16;
    localparam int EXT_W           = 16;
    localparam int ROWS_DEF        = 80;
    localparam int COLS_DEF        = 52;
    localparam int SAMPLE_BITS_DEF = 12;

    localparam logic [N_W-1:0] N_RESET = 16'd100;

    localparam logic CMD_ACC = 1'b0;
    localparam logic CMD_QRY = 1'b1;

    typedef struct packed {
        logic             command;
        logic [PIX_W-1:0] pixel_index;
        logic [SMP_W-1:0] sample;
    } in_item_t;

    typedef struct packed {
        logic [PIX_W-1:0]        result_pixel;
        logic signed [SUM_W-1:0] sample_sum;
        logic [SQ_W-1:0]         square_sum;
        logic [SIGMA_W-1:0]      sigma_q8;
    } out_item_t;

    typedef struct packed {
        logic                    en;
        logic signed [SUM_W-1:0] sum;
        logic [SQ_W-1:0]         sq;
    } mem_wr_t;

    typedef struct packed {
        logic                    start;
        logic signed [SUM_W-1:0] sum;
        logic [SQ_W-1:0]         sq;
        logic [N_W-1:0]          n;
    } sig_req_t;

endpackage

@@ rtl/pna_store.sv @@
// Sum and sum-of-squares memories with the clearing sweep after reset.
module pna_store #(
    parameter int NPIX = 4160,
    parameter int AW   = 13
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             rd_en,
    input  logic [AW-1:0]                    rd_addr,
    output logic signed [pna_pkg::SUM_W-1:0] rd_sum,
    output logic [pna_pkg::SQ_W-1:0]         rd_sq,
    input  logic [AW-1:0]                    wr_addr,
    input  pna_pkg::mem_wr_t                 wr,
    output logic                             clearing
);
    import pna_pkg::*;

    logic signed [SUM_W-1:0] sum_mem [NPIX];
    logic [SQ_W-1:0]         sq_mem  [NPIX];

    logic          clr_reg;
    logic [AW-1:0] clr_cnt_reg;
    logic          we;
    logic [AW-1:0] wa;
    logic signed [SUM_W-1:0] wsum;
    logic [SQ_W-1:0]         wsq;
    logic signed [SUM_W-1:0] rd_sum_reg;
    logic [SQ_W-1:0]         rd_sq_reg;

    assign clearing = clr_reg;
    assign we   = clr_reg | wr.en;
    assign wa   = clr_reg ? clr_cnt_reg : wr_addr;
    assign wsum = clr_reg ? '0 : wr.sum;
    assign wsq  = clr_reg ? '0 : wr.sq;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg     <= 1'b1;
            clr_cnt_reg <= '0;
        end
        else if (clr_reg)
        begin
            if (clr_cnt_reg == AW'(NPIX - 1))
                clr_reg <= 1'b0;
            clr_cnt_reg <= clr_cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            sum_mem[wa] <= wsum;
            sq_mem[wa]  <= wsq;
        end
        if (rd_en)
        begin
            rd_sum_reg <= sum_mem[rd_addr];
            rd_sq_reg  <= sq_mem[rd_addr];
        end
    end

    assign rd_sum = rd_sum_reg;
    assign rd_sq  = rd_sq_reg;

endmodule

@@ rtl/pna_sigma.sv @@
// Multicycle standard deviation: products, restoring divide, digit-serial root.
module pna_sigma (
    input  logic                          clk,
    input  logic                          rst_n,
    input  pna_pkg::sig_req_t             req,
    output logic                          done,
    output logic [pna_pkg::SIGMA_W-1:0]   sigma
);
    import pna_pkg::*;

    localparam int DIV_W  = 70;
    localparam int REM_W  = 33;
    localparam int RT_W   = 28;
    localparam int RV_W   = 2 * RT_W;
    localparam int CNT_W  = 7;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_M0   = 3'd1;
    localparam logic [2:0] S_M1   = 3'd2;
    localparam logic [2:0] S_CMP  = 3'd3;
    localparam logic [2:0] S_DIV  = 3'd4;
    localparam logic [2:0] S_SQRT = 3'd5;
    localparam logic [2:0] S_FIN  = 3'd6;

    logic [2:0]          st_reg;
    logic [CNT_W-1:0]    cnt_reg;
    logic [SUM_W-1:0]    abs_reg;
    logic [SQ_W-1:0]     sq_reg;
    logic [N_W-1:0]      n_reg;
    logic [54:0]         s2_reg;
    logic [34:0]         plo_reg;
    logic [54:0]         nsq_reg;
    logic [31:0]         m_reg;
    logic [DIV_W-1:0]    num_reg;
    logic [REM_W-1:0]    rem_reg;
    logic [RV_W-1:0]     rv_reg;
    logic [RT_W+2:0]     rrem_reg;
    logic [RT_W-1:0]     root_reg;
    logic                done_reg;
    logic [SIGMA_W-1:0]  sigma_reg;

    logic [REM_W-1:0]    rem_sh;
    logic [RT_W+2:0]     rrem_sh;
    logic [RT_W+2:0]     trial;

    assign rem_sh  = {rem_reg[REM_W-2:0], num_reg[DIV_W-1]};
    assign rrem_sh = {rrem_reg[RT_W:0], rv_reg[RV_W-1:RV_W-2]};
    assign trial   = {1'b0, root_reg, 2'b01};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg   <= S_IDLE;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (st_reg)
                S_IDLE:
                begin
                    if (req.start)
                        st_reg <= S_M0;
                end
                S_M0:   st_reg <= S_M1;
                S_M1:   st_reg <= S_CMP;
                S_CMP:
                begin
                    if (n_reg < N_W'(2) || s2_reg >= nsq_reg)
                        st_reg <= S_FIN;
                    else
                        st_reg <= S_DIV;
                end
                S_DIV:
                begin
                    if (cnt_reg == CNT_W'(DIV_W - 1))
                        st_reg <= S_SQRT;
                end
                S_SQRT:
                begin
                    if (cnt_reg == CNT_W'(RT_W - 1))
                        st_reg <= S_FIN;
                end
                S_FIN:
                begin
                    done_reg <= 1'b1;
                    st_reg   <= S_IDLE;
                end
                default: st_reg <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (st_reg)
            S_IDLE:
            begin
                if (req.start)
                begin
                    abs_reg <= req.sum[SUM_W-1] ? SUM_W'(-req.sum) : SUM_W'(req.sum);
                    sq_reg  <= req.sq;
                    n_reg   <= req.n;
                end
            end
            S_M0:
            begin
                s2_reg  <= 55'(abs_reg * abs_reg);
                plo_reg <= 35'(n_reg * sq_reg[18:0]);
            end
            S_M1:
            begin
                nsq_reg <= 55'(plo_reg) + (55'(n_reg * sq_reg[SQ_W-1:19]) << 19);
                m_reg   <= 32'(n_reg * (n_reg - 1'b1));
            end
            S_CMP:
            begin
                num_reg   <= DIV_W'(nsq_reg - s2_reg) << 16;
                rem_reg   <= '0;
                cnt_reg   <= '0;
                root_reg  <= '0;
                rrem_reg  <= '0;
                sigma_reg <= '0;
            end
            S_DIV:
            begin
                if (rem_sh >= REM_W'(m_reg))
                begin
                    rem_reg <= rem_sh - REM_W'(m_reg);
                    num_reg <= {num_reg[DIV_W-2:0], 1'b1};
                end
                else
                begin
                    rem_reg <= rem_sh;
                    num_reg <= {num_reg[DIV_W-2:0], 1'b0};
                end
                if (cnt_reg == CNT_W'(DIV_W - 1))
                begin
                    cnt_reg <= '0;
                    rv_reg  <= {num_reg[RV_W-2:0], (rem_sh >= REM_W'(m_reg))};
                end
                else
                    cnt_reg <= cnt_reg + 1'b1;
            end
            S_SQRT:
            begin
                rv_reg <= rv_reg << 2;
                if (rrem_sh >= trial)
                begin
                    rrem_reg <= rrem_sh - trial;
                    root_reg <= {root_reg[RT_W-2:0], 1'b1};
                end
                else
                begin
                    rrem_reg <= rrem_sh;
                    root_reg <= {root_reg[RT_W-2:0], 1'b0};
                end
                cnt_reg <= cnt_reg + 1'b1;
            end
            S_FIN:
            begin
                if (root_reg > RT_W'({SIGMA_W{1'b1}}))
                    sigma_reg <= '1;
                else
                    sigma_reg <= root_reg[SIGMA_W-1:0];
            end
            default: ;
        endcase
    end

    assign done  = done_reg;
    assign sigma = sigma_reg;

endmodule

@@ rtl/pixel_noise_accumulator.sv @@
// Top level: command sequencer, read-modify-write of the pixel stores, result register.
//
//  channel   signals                       transfer
//  input     start, busy, item             start high while busy low
//  config    cfg_we, cfg_data              cfg_we high (n_readouts)
//  result    done, result                  done high, one cycle, no stall
//
// Accumulate: memory read, then modify and write back.
// Query: memory read, then the sigma unit with its 70-step divider and 28-step root.
// After reset busy stays high while all ROWS*COLS entries (4160 by default) of
// both memories are swept to zero; config writes are taken meanwhile.
// The result is shown for one cycle only; the receiver cannot stall it.
module pixel_noise_accumulator #(
    parameter int ROWS        = pna_pkg::ROWS_DEF,
    parameter int COLS        = pna_pkg::COLS_DEF,
    parameter int SAMPLE_BITS = pna_pkg::SAMPLE_BITS_DEF
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    output logic                     busy,
    input  pna_pkg::in_item_t        item,
    input  logic                     cfg_we,
    input  logic [pna_pkg::N_W-1:0]  cfg_data,
    output logic                     done,
    output pna_pkg::out_item_t       result
);
    import pna_pkg::*;

    localparam int NPIX = ROWS * COLS;
    localparam int AW   = (NPIX > 1) ? $clog2(NPIX) : 1;
    localparam int SH   = EXT_W - SAMPLE_BITS;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_ACC  = 2'd1;
    localparam logic [1:0] ST_QRD  = 2'd2;
    localparam logic [1:0] ST_SIG  = 2'd3;

    logic [1:0]              st_reg, st_next;
    logic [N_W-1:0]          n_reg;
    logic [AW-1:0]           addr_reg;
    logic [PIX_W-1:0]        pix_reg;
    logic                    ok_reg;
    logic signed [EXT_W-1:0] smp_reg;
    logic                    done_reg, done_next;
    out_item_t               res_reg, res_next;

    logic                    accept;
    logic                    pix_ok;
    logic [EXT_W-1:0]        raw_shl;
    logic signed [EXT_W-1:0] smp;
    logic                    clearing;
    logic signed [SUM_W-1:0] rd_sum;
    logic [SQ_W-1:0]         rd_sq;
    mem_wr_t                 wr;
    sig_req_t                sreq;
    logic                    sig_done;
    logic [SIGMA_W-1:0]      sig_val;
    logic signed [SUM_W:0]   ns;
    logic signed [2*EXT_W-1:0] sqp;
    logic [SQ_W:0]           nq;

    assign busy    = clearing | (st_reg != ST_IDLE);
    assign accept  = start & ~busy;
    assign pix_ok  = 32'(item.pixel_index) < NPIX;
    assign raw_shl = EXT_W'(item.sample) << SH;
    assign smp     = $signed(raw_shl) >>> SH;

    pna_store #(.NPIX(NPIX), .AW(AW)) u_store (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_en    (accept & pix_ok),
        .rd_addr  (AW'(item.pixel_index)),
        .rd_sum   (rd_sum),
        .rd_sq    (rd_sq),
        .wr_addr  (addr_reg),
        .wr       (wr),
        .clearing (clearing)
    );

    pna_sigma u_sigma (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (sreq),
        .done  (sig_done),
        .sigma (sig_val)
    );

    assign ns  = (SUM_W+1)'(rd_sum) + (SUM_W+1)'(smp_reg);
    assign sqp = smp_reg * smp_reg;
    assign nq  = (SQ_W+1)'(rd_sq) + (SQ_W+1)'($unsigned(sqp));

    always_comb
    begin
        st_next   = st_reg;
        done_next = 1'b0;
        res_next  = res_reg;
        wr        = '0;
        sreq      = '0;
        sreq.sum  = rd_sum;
        sreq.sq   = rd_sq;
        sreq.n    = n_reg;
        case (st_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (item.command == CMD_QRY)
                        st_next = ST_QRD;
                    else if (pix_ok)
                        st_next = ST_ACC;
                end
            end
            ST_ACC:
            begin
                wr.en = 1'b1;
                if (ns[SUM_W] != ns[SUM_W-1])
                    wr.sum = ns[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}}
                                       : {1'b0, {(SUM_W-1){1'b1}}};
                else
                    wr.sum = ns[SUM_W-1:0];
                wr.sq   = nq[SQ_W] ? '1 : nq[SQ_W-1:0];
                st_next = ST_IDLE;
            end
            ST_QRD:
            begin
                res_next.result_pixel = pix_reg;
                res_next.sigma_q8     = '0;
                if (ok_reg)
                begin
                    wr.en                = 1'b1;
                    sreq.start           = 1'b1;
                    res_next.sample_sum  = rd_sum;
                    res_next.square_sum  = rd_sq;
                    st_next              = ST_SIG;
                end
                else
                begin
                    res_next.sample_sum = '0;
                    res_next.square_sum = '0;
                    done_next           = 1'b1;
                    st_next             = ST_IDLE;
                end
            end
            ST_SIG:
            begin
                if (sig_done)
                begin
                    res_next.sigma_q8 = sig_val;
                    done_next         = 1'b1;
                    st_next           = ST_IDLE;
                end
            end
            default: st_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg   <= ST_IDLE;
            done_reg <= 1'b0;
            n_reg    <= N_RESET;
        end
        else
        begin
            st_reg   <= st_next;
            done_reg <= done_next;
            if (cfg_we)
                n_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
        if (accept)
        begin
            addr_reg <= AW'(item.pixel_index);
            pix_reg  <= item.pixel_index;
            ok_reg   <= pix_ok;
            smp_reg  <= smp;
        end
    end

    assign done   = done_reg;
    assign result = res_reg;

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done) else $error("result strobe held two cycles");
    a_clear_busy: assert property (@(posedge clk) disable iff (!rst_n)
        clearing |-> busy) else $error("input taken during clearing sweep");
    a_acc_write: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && item.command == CMD_ACC && pix_ok) |=> (wr.en && st_reg == ST_ACC))
        else $error("accumulate without write back");
    a_sig_idle: assert property (@(posedge clk) disable iff (!rst_n)
        sig_done |-> st_reg == ST_SIG) else $error("sigma finished outside a query");

endmodule
